### hw/rtl/obhp_pkg.sv
package obhp_pkg;

   localparam int unsigned HdrBytes = 22;

   localparam logic [4:0] HDR_LAST_COUNT = 5'(HdrBytes);
   localparam logic [4:0] LAST_EXT_POS   = 5'd16;

   localparam logic [7:0] FLAG_UNSUPPORTED = 8'h6F;
   localparam logic [7:0] FLAG_CHAIN       = 8'h80;
   localparam logic [7:0] FLAG_WIDE        = 8'h10;
   localparam logic [7:0] DEPTH_MONO       = 8'h01;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_UNDERFLOW = 3'd1;
   localparam logic [2:0] ST_FLAGS     = 3'd2;
   localparam logic [2:0] ST_CHAIN     = 3'd3;
   localparam logic [2:0] ST_DEPTH     = 3'd4;

   typedef enum logic [2:0] {
      PH_INFO  = 3'd0,
      PH_EXT   = 3'd1,
      PH_W0    = 3'd2,
      PH_W1    = 3'd3,
      PH_H0    = 3'd4,
      PH_H1    = 3'd5,
      PH_DEPTH = 3'd6,
      PH_DONE  = 3'd7
   } phase_type;

   // Finished header as handed from the parser to the length stage.
   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] width;
      logic [15:0] height;
      logic [4:0]  offset;
   } hdr_rec_type;

endpackage

### hw/rtl/ota_bitmap_header_parser.sv
// Channel  Dir  Handshake          Payload
// req      in   req_tvalid/tready  tdata[7:0] data_byte, tlast end_of_data
// rsp      out  rsp_tvalid/tready  tdata status, width, height, header_length, data_length
//
// One header byte is taken per cycle while req_tready is high; the parser
// state updates in that cycle. A finished header is held in a record register,
// where the pixel byte count (16x16 multiply) is formed, then lands in the
// response register.
// reset is synchronous and returns the parser to the info byte.
// req_tready drops only while both the record and response registers are full
// and rsp_tready is low.
module ota_bitmap_header_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata    // [2:0] status, [18:3] image_width,
                                    // [34:19] image_height, [39:35] header_length,
                                    // [69:40] data_length, [71:70] zero
);

   logic                  take;
   logic                  done;
   obhp_pkg::hdr_rec_type rec;
   logic                  out_free;
   logic                  hdr_valid_ff, hdr_valid_in;
   obhp_pkg::hdr_rec_type hdr_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [2:0]            status_ff;
   logic [15:0]           width_ff;
   logic [15:0]           height_ff;
   logic [4:0]            hlen_ff;
   logic [29:0]           dlen_ff, dlen_in;
   logic [32:0]           pixels;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !hdr_valid_ff || out_free;
   assign take       = req_tvalid && req_tready;

   obhp_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .data_byte   (req_tdata),
      .end_of_data (req_tlast),
      .done        (done),
      .rec         (rec)
   );

   always_comb begin
      // full 32-bit product, extended before the rounding add
      pixels  = {1'b0, {16'h0000, hdr_ff.width} * {16'h0000, hdr_ff.height}} + 33'd7;
      dlen_in = 30'(pixels[32:3]) + 30'(hdr_ff.offset);

      if (take && done) begin
         hdr_valid_in = 1'b1;
      end else if (out_free) begin
         hdr_valid_in = 1'b0;
      end else begin
         hdr_valid_in = hdr_valid_ff;
      end

      if (out_free) begin
         rsp_valid_in = hdr_valid_ff;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hdr_valid_ff <= hdr_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && done) begin
         hdr_ff <= rec;
      end
      if (out_free && hdr_valid_ff) begin
         status_ff <= hdr_ff.status;
         width_ff  <= hdr_ff.width;
         height_ff <= hdr_ff.height;
         hlen_ff   <= hdr_ff.offset;
         dlen_ff   <= dlen_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, dlen_ff, hlen_ff, height_ff, width_ff, status_ff};

`ifndef NO_ASSERTIONS
   a_last_byte_closes: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> hdr_valid_ff)
      else $error("last byte did not close a header");

   a_record_holds: assert property (@(posedge clock) disable iff (reset)
      hdr_valid_ff && !out_free |=> hdr_valid_ff && $stable(hdr_ff))
      else $error("pending header record lost while output stalled");

   a_fail_zeroes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff != obhp_pkg::ST_OK |->
         width_ff == 16'd0 && height_ff == 16'd0 && hlen_ff == 5'd0 && dlen_ff == 30'd0)
      else $error("failed header carries nonzero fields");

   a_ok_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == obhp_pkg::ST_OK |->
         hlen_ff >= 5'd4 && hlen_ff <= 5'(obhp_pkg::HdrBytes) && dlen_ff >= 30'(hlen_ff))
      else $error("good header has impossible lengths");
`endif

endmodule

### hw/rtl/obhp_parse.sv
module obhp_parse (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     take,
   input  logic [7:0]               data_byte,
   input  logic                     end_of_data,
   output logic                     done,
   output obhp_pkg::hdr_rec_type    rec
);

   logic [4:0]          count_ff, count_in, count_nx;
   obhp_pkg::phase_type phase_ff, phase_in, phase_nx;
   logic [7:0]          info_ff, info_in, info_nx;
   logic [15:0]         width_ff, width_in, width_nx;
   logic [15:0]         height_ff, height_in, height_nx;
   logic [4:0]          offset_ff, offset_in, offset_nx;
   logic [2:0]          err_ff, err_in, err_nx;
   logic                wide;
   logic [2:0]          status;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         phase_ff  <= obhp_pkg::PH_INFO;
         info_ff   <= '0;
         width_ff  <= '0;
         height_ff <= '0;
         offset_ff <= '0;
         err_ff    <= obhp_pkg::ST_OK;
      end else if (take) begin
         count_ff  <= count_in;
         phase_ff  <= phase_in;
         info_ff   <= info_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         offset_ff <= offset_in;
         err_ff    <= err_in;
      end
   end

   always_comb begin
      wide      = (info_ff & obhp_pkg::FLAG_WIDE) != 8'h00;
      count_nx  = count_ff + 5'd1;
      phase_nx  = phase_ff;
      info_nx   = info_ff;
      width_nx  = width_ff;
      height_nx = height_ff;
      offset_nx = offset_ff;
      err_nx    = err_ff;
      case (phase_ff)
         obhp_pkg::PH_INFO: begin
            info_nx = data_byte;
            if ((data_byte & obhp_pkg::FLAG_UNSUPPORTED) != 8'h00) begin
               err_nx   = obhp_pkg::ST_FLAGS;
               phase_nx = obhp_pkg::PH_DONE;
            end else if ((data_byte & obhp_pkg::FLAG_CHAIN) != 8'h00) begin
               phase_nx = obhp_pkg::PH_EXT;
            end else begin
               phase_nx = obhp_pkg::PH_W0;
            end
         end
         obhp_pkg::PH_EXT: begin
            if ((data_byte & obhp_pkg::FLAG_CHAIN) == 8'h00) begin
               phase_nx = obhp_pkg::PH_W0;
            end else if (count_ff >= obhp_pkg::LAST_EXT_POS) begin
               err_nx   = obhp_pkg::ST_CHAIN;
               phase_nx = obhp_pkg::PH_DONE;
            end
         end
         obhp_pkg::PH_W0: begin
            width_nx = {8'h00, data_byte};
            phase_nx = wide ? obhp_pkg::PH_W1 : obhp_pkg::PH_H0;
         end
         obhp_pkg::PH_W1: begin
            width_nx = {data_byte, width_ff[7:0]};
            phase_nx = obhp_pkg::PH_H0;
         end
         obhp_pkg::PH_H0: begin
            height_nx = {8'h00, data_byte};
            phase_nx  = wide ? obhp_pkg::PH_H1 : obhp_pkg::PH_DEPTH;
         end
         obhp_pkg::PH_H1: begin
            height_nx = {data_byte, height_ff[7:0]};
            phase_nx  = obhp_pkg::PH_DEPTH;
         end
         obhp_pkg::PH_DEPTH: begin
            phase_nx = obhp_pkg::PH_DONE;
            if (data_byte != obhp_pkg::DEPTH_MONO) begin
               err_nx = obhp_pkg::ST_DEPTH;
            end else begin
               offset_nx = count_nx;
            end
         end
         default: begin
         end
      endcase

      done = (count_nx == obhp_pkg::HDR_LAST_COUNT) || end_of_data;

      // short stream wins over any fault seen so far
      if (count_nx != obhp_pkg::HDR_LAST_COUNT) begin
         status = obhp_pkg::ST_UNDERFLOW;
      end else if (err_nx != obhp_pkg::ST_OK) begin
         status = err_nx;
      end else if (phase_nx != obhp_pkg::PH_DONE) begin
         status = obhp_pkg::ST_UNDERFLOW;
      end else begin
         status = obhp_pkg::ST_OK;
      end

      rec.status = status;
      if (status == obhp_pkg::ST_OK) begin
         rec.width  = width_nx;
         rec.height = height_nx;
         rec.offset = offset_nx;
      end else begin
         rec.width  = '0;
         rec.height = '0;
         rec.offset = '0;
      end

      // a finished header leaves the parser as after reset
      if (done) begin
         count_in  = '0;
         phase_in  = obhp_pkg::PH_INFO;
         info_in   = '0;
         width_in  = '0;
         height_in = '0;
         offset_in = '0;
         err_in    = obhp_pkg::ST_OK;
      end else begin
         count_in  = count_nx;
         phase_in  = phase_nx;
         info_in   = info_nx;
         width_in  = width_nx;
         height_in = height_nx;
         offset_in = offset_nx;
         err_in    = err_nx;
      end
   end

endmodule

### bench/tb_top.sv
module tb_top;

   localparam int HdrLen      = 22;
   localparam int ReportLimit = 10;
   localparam int NoEnd       = -1;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] width;
      logic [15:0] height;
      logic [4:0]  hdr_len;
      logic [29:0] data_len;
   } header_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [7:0] data_byte
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;        // [2:0] status, [18:3] image_width, [34:19] image_height,
                                  // [39:35] header_length, [69:40] data_length, [71:70] zero

   int send_idle_pct     = 0;
   int recv_stall_pct    = 0;
   int error_count       = 0;
   int bytes_sent        = 0;
   int headers_predicted = 0;

   header_result_type expected_headers[$];
   logic [7:0]        hdr_buf [HdrLen];

   // parser state as the bench tracks it
   logic [4:0]          mir_count  = '0;
   obhp_pkg::phase_type mir_phase  = obhp_pkg::PH_INFO;
   logic [7:0]          mir_info   = '0;
   logic [15:0]         mir_width  = '0;
   logic [15:0]         mir_height = '0;
   logic [4:0]          mir_offset = '0;
   logic [2:0]          mir_err    = obhp_pkg::ST_OK;

   ota_bitmap_header_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic mirror_fail(input logic [2:0] code);
      mir_err   = code;
      mir_phase = obhp_pkg::PH_DONE;
   endtask

   task automatic predict_header_byte(input logic [7:0] b, input logic last);
      logic [4:0]        pos;
      logic              wide;
      logic [63:0]       pixels;
      header_result_type res;
      pos  = mir_count;
      wide = (mir_info & obhp_pkg::FLAG_WIDE) != '0;
      case (mir_phase)
         obhp_pkg::PH_INFO: begin
            mir_info = b;
            if ((b & obhp_pkg::FLAG_UNSUPPORTED) != '0) mirror_fail(obhp_pkg::ST_FLAGS);
            else if ((b & obhp_pkg::FLAG_CHAIN) != '0) mir_phase = obhp_pkg::PH_EXT;
            else mir_phase = obhp_pkg::PH_W0;
         end
         obhp_pkg::PH_EXT: begin
            if ((b & obhp_pkg::FLAG_CHAIN) == '0) mir_phase = obhp_pkg::PH_W0;
            else if (pos >= obhp_pkg::LAST_EXT_POS) mirror_fail(obhp_pkg::ST_CHAIN);
         end
         obhp_pkg::PH_W0: begin
            mir_width = {8'h00, b};
            mir_phase = wide ? obhp_pkg::PH_W1 : obhp_pkg::PH_H0;
         end
         obhp_pkg::PH_W1: begin
            mir_width = {b, mir_width[7:0]};
            mir_phase = obhp_pkg::PH_H0;
         end
         obhp_pkg::PH_H0: begin
            mir_height = {8'h00, b};
            mir_phase  = wide ? obhp_pkg::PH_H1 : obhp_pkg::PH_DEPTH;
         end
         obhp_pkg::PH_H1: begin
            mir_height = {b, mir_height[7:0]};
            mir_phase  = obhp_pkg::PH_DEPTH;
         end
         obhp_pkg::PH_DEPTH: begin
            if (b != obhp_pkg::DEPTH_MONO) begin
               mirror_fail(obhp_pkg::ST_DEPTH);
            end else begin
               mir_offset = pos + 5'd1;
               mir_phase  = obhp_pkg::PH_DONE;
            end
         end
         default: ;
      endcase
      mir_count = pos + 5'd1;

      if (mir_count == obhp_pkg::HDR_LAST_COUNT || last) begin
         res = '0;
         if (mir_count < obhp_pkg::HDR_LAST_COUNT) begin
            res.status = obhp_pkg::ST_UNDERFLOW;
         end else if (mir_err != obhp_pkg::ST_OK) begin
            res.status = mir_err;
         end else if (mir_phase != obhp_pkg::PH_DONE) begin
            res.status = obhp_pkg::ST_UNDERFLOW;
         end else begin
            res.status   = obhp_pkg::ST_OK;
            res.width    = mir_width;
            res.height   = mir_height;
            res.hdr_len  = mir_offset;
            pixels       = 64'(mir_width) * 64'(mir_height);
            res.data_len = 30'(64'(mir_offset) + ((pixels + 64'd7) >> 3));
         end
         expected_headers.push_back(res);
         headers_predicted++;
         // next byte opens a new header
         mir_count  = '0;
         mir_phase  = obhp_pkg::PH_INFO;
         mir_info   = '0;
         mir_width  = '0;
         mir_height = '0;
         mir_offset = '0;
         mir_err    = obhp_pkg::ST_OK;
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      predict_header_byte(b, last);
      bytes_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_headers.size() != 0) @(posedge clock);
   endtask

   task automatic place_byte(inout int idx, input logic [7:0] b);
      if (idx < HdrLen) hdr_buf[idx] = b;
      idx++;
   endtask

   // Random filler everywhere, then info, extension chain, dimensions and depth.
   task automatic build_header(input logic [7:0] info, input int chain_len,
                               input logic [15:0] w, input logic [15:0] h,
                               input logic [7:0] depth);
      int  idx;
      logic wide;
      for (int i = 0; i < HdrLen; i++) hdr_buf[i] = 8'($urandom);
      wide = (info & obhp_pkg::FLAG_WIDE) != '0;
      idx  = 0;
      place_byte(idx, info);
      if ((info & obhp_pkg::FLAG_CHAIN) != '0) begin
         for (int i = 0; i < chain_len; i++)
            place_byte(idx, 8'($urandom) | obhp_pkg::FLAG_CHAIN);
         place_byte(idx, 8'($urandom) & ~obhp_pkg::FLAG_CHAIN);
      end
      place_byte(idx, w[7:0]);
      if (wide) place_byte(idx, w[15:8]);
      place_byte(idx, h[7:0]);
      if (wide) place_byte(idx, h[15:8]);
      place_byte(idx, depth);
   endtask

   task automatic send_header(input int eod_at);
      int n;
      n = (eod_at >= 0 && eod_at < HdrLen) ? eod_at + 1 : HdrLen;
      for (int i = 0; i < n; i++) send_byte(hdr_buf[i], i == eod_at);
   endtask

   task automatic check_header_result(input logic [71:0] data);
      header_result_type got;
      header_result_type want;
      got.status   = data[2:0];
      got.width    = data[18:3];
      got.height   = data[34:19];
      got.hdr_len  = data[39:35];
      got.data_len = data[69:40];
      if (expected_headers.size() == 0) begin
         error_count++;
         if (error_count <= ReportLimit)
            $display("unexpected result transfer: %h", data);
      end else begin
         want = expected_headers.pop_front();
         if (got.status !== want.status || got.width !== want.width ||
             got.height !== want.height || got.hdr_len !== want.hdr_len ||
             got.data_len !== want.data_len) begin
            error_count++;
            if (error_count <= ReportLimit)
               $display({"mismatch: exp st=%0d w=%0d h=%0d hl=%0d dl=%0d",
                         "  got st=%0d w=%0d h=%0d hl=%0d dl=%0d"},
                        want.status, want.width, want.height, want.hdr_len,
                        want.data_len, got.status, got.width, got.height,
                        got.hdr_len, got.data_len);
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_header_result(rsp_tdata);
      rsp_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
   end

   function automatic logic [15:0] pick_dim();
      case ($urandom_range(3, 0))
         0: return 16'($urandom_range(15, 0));
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic test_normal_headers();
      build_header(8'h00, 0, 16'h00FF, 16'h00FF, obhp_pkg::DEPTH_MONO);
      send_header(NoEnd);
      build_header(8'h00, 0, 16'h0000, 16'h0000, obhp_pkg::DEPTH_MONO);
      send_header(NoEnd);
   endtask

   task automatic test_wide_headers();
      // largest image: pixel count must not wrap
      build_header(obhp_pkg::FLAG_WIDE, 0, 16'hFFFF, 16'hFFFF, obhp_pkg::DEPTH_MONO);
      send_header(NoEnd);
      build_header(obhp_pkg::FLAG_WIDE, 0, 16'h0100, 16'h0001, obhp_pkg::DEPTH_MONO);
      send_header(NoEnd);
   endtask

   task automatic test_flag_faults();
      build_header(obhp_pkg::FLAG_UNSUPPORTED | obhp_pkg::FLAG_CHAIN | obhp_pkg::FLAG_WIDE,
                   3, 16'h0010, 16'h0010, obhp_pkg::DEPTH_MONO);
      send_header(NoEnd);
      build_header(8'h40, 0, 16'h0010, 16'h0010, obhp_pkg::DEPTH_MONO);
      send_header(NoEnd);
   endtask

   task automatic test_chain_lengths();
      build_header(obhp_pkg::FLAG_CHAIN, 15, 16'h00AB, 16'h00CD, obhp_pkg::DEPTH_MONO);
      send_header(NoEnd);
      // longest legal chain with wide dims: header fills all 22 bytes
      build_header(obhp_pkg::FLAG_CHAIN | obhp_pkg::FLAG_WIDE, 15, 16'hFFFF, 16'h0001,
                   obhp_pkg::DEPTH_MONO);
      send_header(NoEnd);
      build_header(obhp_pkg::FLAG_CHAIN, 16, 16'h0001, 16'h0001, obhp_pkg::DEPTH_MONO);
      send_header(NoEnd);
   endtask

   task automatic test_depth_faults();
      build_header(8'h00, 0, 16'h0008, 16'h0008, 8'h00);
      send_header(NoEnd);
      build_header(obhp_pkg::FLAG_WIDE, 0, 16'h0008, 16'h0008, 8'hFF);
      send_header(NoEnd);
      build_header(obhp_pkg::FLAG_CHAIN, 2, 16'h0008, 16'h0008, 8'h03);
      send_header(NoEnd);
   endtask

   task automatic test_short_streams();
      build_header(8'h00, 0, 16'h0005, 16'h0005, obhp_pkg::DEPTH_MONO);
      send_header(0);
      build_header(8'h00, 0, 16'h0005, 16'h0005, obhp_pkg::DEPTH_MONO);
      send_header(HdrLen - 2);
      // end marker on the closing byte is a normal finish
      build_header(obhp_pkg::FLAG_WIDE, 0, 16'h0123, 16'h0456, obhp_pkg::DEPTH_MONO);
      send_header(HdrLen - 1);
   endtask

   task automatic test_random_headers(input int byte_goal, input int header_goal);
      logic [7:0]  info;
      logic [7:0]  depth;
      int          chain_len;
      int          eod_at;
      int          start_bytes;
      int          start_headers;
      start_bytes   = bytes_sent;
      start_headers = headers_predicted;
      while (bytes_sent - start_bytes < byte_goal ||
             headers_predicted - start_headers < header_goal) begin
         if ($urandom_range(9, 0) == 0) begin
            info = 8'($urandom);
         end else begin
            info = ($urandom_range(1, 0) != 0) ? obhp_pkg::FLAG_CHAIN : 8'h00;
            if ($urandom_range(1, 0) != 0) info = info | obhp_pkg::FLAG_WIDE;
         end
         chain_len = ($urandom_range(7, 0) == 0) ? $urandom_range(17, 14)
                                                 : $urandom_range(5, 0);
         depth  = ($urandom_range(6, 0) == 0) ? 8'($urandom) : obhp_pkg::DEPTH_MONO;
         eod_at = ($urandom_range(4, 0) == 0) ? $urandom_range(HdrLen - 1, 0) : NoEnd;
         build_header(info, chain_len, pick_dim(), pick_dim(), depth);
         send_header(eod_at);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_normal_headers();
      test_wide_headers();
      test_flag_faults();
      test_chain_lengths();
      test_depth_faults();
      test_short_streams();
      wait_drained();

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      test_random_headers(90, 4);
      wait_drained();

      send_idle_pct  = 64;
      recv_stall_pct = 0;
      test_random_headers(90, 4);
      wait_drained();

      send_idle_pct  = 0;
      recv_stall_pct = 64;
      test_random_headers(90, 4);
      wait_drained();

      send_idle_pct  = 20;
      recv_stall_pct = 20;
      test_random_headers(90, 4);
      wait_drained();

      repeat (8) @(posedge clock);
      if (error_count == 0 && expected_headers.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

endmodule

### ota_bitmap_header_parser.f
hw/rtl/obhp_pkg.sv
hw/rtl/obhp_parse.sv
hw/rtl/ota_bitmap_header_parser.sv
bench/tb_top.sv
